### src/lz_backref_decompressor_defines.svh
// assertion macros for the lz back-reference decompressor checker
// no dependencies; included by the checker file
`ifndef LZ_BACKREF_DECOMPRESSOR_DEFINES_SVH
`define LZ_BACKREF_DECOMPRESSOR_DEFINES_SVH

// clocked check, switched off while reset is held
`define LZBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define LZBD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/lzbd_pkg.sv
// shared types and constants of the lz back-reference decompressor
// no dependencies; used by every rtl file of the block but the fifo
package lzbd_pkg;

    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int DIST_W            = 17;
    localparam int LEN_W             = 7;
    localparam int CMD_DEPTH         = 2;
    localparam int OUT_DEPTH         = 4;

    localparam logic [7:0] LEN_MASK = 8'h3f;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIST = 2'd1;
    localparam logic [1:0] ERR_END  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_END
    } t_cmd_kind;

    // one decoded token handed from parser to executor
    typedef struct packed {
        t_cmd_kind               kind;
        logic [7:0]              data;
        logic [DIST_W-1:0]       offset;
        logic [LEN_W-1:0]        len;
        logic                    end_err;
        logic                    restart;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } t_result;

endpackage

### src/lzbd_fifo.sv
// small register-based fifo used for the command and result queues
// depends on nothing but its parameters
module lzbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);
    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd;
    logic [PW-1:0]    r_wr;
    logic [LW-1:0]    r_level;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_level != LW'(DEPTH));
    assign do_pop  = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

### src/lzbd_front.sv
// token parser: classifies compressed bytes and emits commands
// depends on lzbd_pkg
module lzbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_cmd_push,
    output lzbd_pkg::t_cmd  o_cmd
);
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LIT,
        PH_DHI,
        PH_DLO
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [7:0]                    r_lit, n_lit;
    logic [lzbd_pkg::LEN_W-1:0]    r_len, n_len;
    logic [7:0]                    r_dhi, n_dhi;
    logic [7:0]                    lit_dec;
    logic                          emit;
    lzbd_pkg::t_cmd                cmd;

    always_comb begin
        n_phase     = r_phase;
        n_lit       = r_lit;
        n_len       = r_len;
        n_dhi       = r_dhi;
        emit        = 1'b0;
        lit_dec     = (r_lit != '0) ? r_lit - 8'd1 : '0;
        cmd.kind    = lzbd_pkg::CMD_END;
        cmd.data    = i_byte;
        cmd.offset  = lzbd_pkg::DIST_W'({r_dhi, i_byte}) + lzbd_pkg::DIST_W'(1);
        cmd.len     = r_len;
        cmd.end_err = 1'b0;
        cmd.restart = i_last;

        unique case (r_phase)
            PH_IDLE: begin
                if (!i_byte[7]) begin
                    n_lit   = 8'({1'b0, i_byte[6:0]}) + 8'd1;
                    n_phase = PH_LIT;
                end else begin
                    n_len   = lzbd_pkg::LEN_W'(i_byte & lzbd_pkg::LEN_MASK)
                              + lzbd_pkg::LEN_W'(1);
                    n_dhi   = '0;
                    n_phase = i_byte[6] ? PH_DLO : PH_DHI;
                end
            end
            PH_LIT: begin
                emit     = 1'b1;
                cmd.kind = lzbd_pkg::CMD_LIT;
                n_lit    = lit_dec;
                n_phase  = (lit_dec == '0) ? PH_IDLE : PH_LIT;
            end
            PH_DHI: begin
                n_dhi   = i_byte;
                n_phase = PH_DLO;
            end
            PH_DLO: begin
                emit     = 1'b1;
                cmd.kind = lzbd_pkg::CMD_COPY;
                n_phase  = PH_IDLE;
                n_dhi    = '0;
                n_len    = '0;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // end of stream: flag an unfinished token, then restart the parser
        if (i_last) begin
            emit        = 1'b1;
            cmd.end_err = (n_phase != PH_IDLE);
            n_phase     = PH_IDLE;
            n_lit       = '0;
            n_len       = '0;
            n_dhi       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lit   <= '0;
            r_len   <= '0;
            r_dhi   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_len   <= n_len;
            r_dhi   <= n_dhi;
        end
    end

    assign o_cmd_push = i_accept && emit;
    assign o_cmd      = cmd;

endmodule

### src/lzbd_back.sv
// command executor: history memory, copy engine and result queue
// depends on lzbd_pkg and lzbd_fifo
module lzbd_back #(
    parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  lzbd_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output lzbd_pkg::t_result  o_result
);
    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int PW  = $clog2(HISTORY_DEPTH + 1);
    localparam int DW  = lzbd_pkg::DIST_W;
    localparam int OLW = $clog2(lzbd_pkg::OUT_DEPTH + 1);
    localparam int RW  = $bits(lzbd_pkg::t_result);

    typedef enum logic [1:0] {
        S_HEAD,
        S_COPY,
        S_TAIL
    } t_state;

    // issue stage
    t_state                       r_state, n_state;
    logic [lzbd_pkg::LEN_W-1:0]   r_left, n_left;
    logic [AW-1:0]                r_wp;
    logic [PW-1:0]                r_prod;
    logic [AW-1:0]                wp_inc;
    logic [PW-1:0]                prod_inc;
    logic [DW-1:0]                wp_x;
    logic [DW-1:0]                rd_x;
    logic [AW-1:0]                rd_addr;
    logic                         room;
    logic                         dist_far;
    logic                         go;
    logic                         fin;
    logic                         iss_mem;
    logic                         iss_write;
    logic [7:0]                   iss_byte;
    logic                         iss_last;
    logic [1:0]                   iss_err;

    // history memory and write-back stage
    logic [7:0]                   r_hist [HISTORY_DEPTH];
    logic [7:0]                   r_q;
    logic                         r_b_valid;
    logic                         r_b_mem;
    logic                         r_b_write;
    logic [AW-1:0]                r_b_addr;
    logic [7:0]                   r_b_byte;
    logic                         r_b_last;
    logic [1:0]                   r_b_err;
    logic                         r_b_fwd;
    logic [7:0]                   r_b_fwd_data;
    logic [7:0]                   b_value;

    // result queue
    lzbd_pkg::t_result            res_in;
    logic [RW-1:0]                res_bits;
    logic [OLW-1:0]               out_level;

    assign wp_inc   = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign prod_inc = (r_prod < PW'(HISTORY_DEPTH)) ? r_prod + 1'b1 : r_prod;

    // source address wraps modulo the history depth
    assign wp_x     = DW'(r_wp);
    assign rd_x     = (wp_x >= i_cmd.offset) ? wp_x - i_cmd.offset
                                             : wp_x + DW'(HISTORY_DEPTH) - i_cmd.offset;
    assign rd_addr  = rd_x[AW-1:0];
    assign dist_far = i_cmd.offset > DW'(r_prod);

    // a slot in the result queue for this issue and the one in write-back
    assign room = ((OLW + 1)'(out_level) + (OLW + 1)'(r_b_valid))
                  < (OLW + 1)'(lzbd_pkg::OUT_DEPTH);

    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        go        = 1'b0;
        fin       = 1'b0;
        iss_mem   = 1'b0;
        iss_write = 1'b0;
        iss_byte  = i_cmd.data;
        iss_last  = 1'b0;
        iss_err   = lzbd_pkg::ERR_NONE;

        if (i_cmd_valid && room) begin
            unique case (r_state)
                S_HEAD: begin
                    go = 1'b1;
                    unique case (i_cmd.kind)
                        lzbd_pkg::CMD_LIT: begin
                            iss_write = 1'b1;
                            if (i_cmd.end_err) begin
                                n_state = S_TAIL;
                            end else begin
                                iss_last = 1'b1;
                                fin      = 1'b1;
                            end
                        end
                        lzbd_pkg::CMD_COPY: begin
                            if (dist_far) begin
                                iss_err  = lzbd_pkg::ERR_DIST;
                                iss_byte = '0;
                                iss_last = 1'b1;
                                fin      = 1'b1;
                            end else begin
                                iss_mem   = 1'b1;
                                iss_write = 1'b1;
                                if (i_cmd.len <= lzbd_pkg::LEN_W'(1)) begin
                                    iss_last = 1'b1;
                                    fin      = 1'b1;
                                end else begin
                                    n_left  = i_cmd.len - 1'b1;
                                    n_state = S_COPY;
                                end
                            end
                        end
                        default: begin
                            iss_err  = lzbd_pkg::ERR_END;
                            iss_byte = '0;
                            iss_last = 1'b1;
                            fin      = 1'b1;
                        end
                    endcase
                end
                S_COPY: begin
                    go        = 1'b1;
                    iss_mem   = 1'b1;
                    iss_write = 1'b1;
                    if (r_left <= lzbd_pkg::LEN_W'(1)) begin
                        iss_last = 1'b1;
                        fin      = 1'b1;
                        n_state  = S_HEAD;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end
                S_TAIL: begin
                    go       = 1'b1;
                    iss_err  = lzbd_pkg::ERR_END;
                    iss_byte = '0;
                    iss_last = 1'b1;
                    fin      = 1'b1;
                    n_state  = S_HEAD;
                end
                default: begin
                    n_state = S_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_HEAD;
            r_left    <= '0;
            r_wp      <= '0;
            r_prod    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_b_valid <= go;
            if (go && iss_write) begin
                r_wp   <= wp_inc;
                r_prod <= prod_inc;
            end
            if (fin && i_cmd.restart) begin
                r_wp   <= '0;
                r_prod <= '0;
            end
        end
    end

    // write-back stage payload; forward the byte written while a read hits it
    always_ff @(posedge i_clk) begin
        r_b_mem      <= iss_mem;
        r_b_write    <= go && iss_write;
        r_b_addr     <= r_wp;
        r_b_byte     <= iss_byte;
        r_b_last     <= iss_last;
        r_b_err      <= iss_err;
        r_b_fwd      <= r_b_valid && r_b_write && (rd_addr == r_b_addr);
        r_b_fwd_data <= b_value;
    end

    assign b_value = r_b_mem ? (r_b_fwd ? r_b_fwd_data : r_q) : r_b_byte;

    always_ff @(posedge i_clk) begin
        r_q <= r_hist[rd_addr];
        if (r_b_valid && r_b_write) begin
            r_hist[r_b_addr] <= b_value;
        end
    end

    assign res_in.data = b_value;
    assign res_in.last = r_b_last;
    assign res_in.err  = r_b_err;
    assign o_cmd_pop   = fin;

    lzbd_fifo #(
        .WIDTH (RW),
        .DEPTH (lzbd_pkg::OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_valid),
        .i_data  (res_in),
        .i_pop   (i_pop),
        .o_data  (res_bits),
        .o_empty (o_empty),
        .o_level (out_level)
    );

    assign o_result = lzbd_pkg::t_result'(res_bits);

endmodule

### src/lz_backref_decompressor.sv
// top level of the byte-oriented lz back-reference decompressor
// depends on lzbd_pkg, lzbd_front, lzbd_fifo and lzbd_back
//
// usage:
//   input channel: drive i_in_byte/i_in_last with push; a byte is taken at a
//   clock edge where push is high and full is low. i_in_last marks the final
//   byte of a compressed stream; parser and history restart after it.
//   result channel: while empty is low the oldest result is on o_out_byte,
//   o_out_last, o_out_error; it is taken at an edge where pop is high.
//   o_out_last marks the final result caused by one input byte.
// timing:
//   the parser takes one byte per cycle while its 2-entry command queue has
//   room. the executor issues one result per cycle while it has a command
//   and the result queue has room: a literal or an error gives one result, a
//   copy one per byte of its length (1 to 64), read from the history memory;
//   control and distance bytes give none of their own.
// stalls: when pop stays low the 4-entry result queue fills, the executor
//   stops, then the command queue fills and full rises.
// reset: synchronous, active low; clears parser, queues and pointers. the
//   history memory is not cleared; the distance check never reads stale data.
module lz_backref_decompressor #(
    parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_out_error
);
    localparam int CLW = $clog2(lzbd_pkg::CMD_DEPTH + 1);
    localparam int CW  = $bits(lzbd_pkg::t_cmd);

    logic               in_take;
    logic               cmd_push;
    lzbd_pkg::t_cmd     cmd_in;
    logic [CW-1:0]      cmd_bits;
    lzbd_pkg::t_cmd     cmd_head;
    logic               cmd_empty;
    logic [CLW-1:0]     cmd_level;
    logic               cmd_pop;
    lzbd_pkg::t_result  result;

    // back pressure comes straight from the command queue fill level
    assign full    = (cmd_level == CLW'(lzbd_pkg::CMD_DEPTH));
    assign in_take = push && !full;

    // parser: control, literal and distance bytes become commands
    lzbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_take),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // decouples the parser from the copy engine
    lzbd_fifo #(
        .WIDTH (CW),
        .DEPTH (lzbd_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (cmd_empty),
        .o_level (cmd_level)
    );

    assign cmd_head = lzbd_pkg::t_cmd'(cmd_bits);

    // executor: history memory, copy loop and result queue
    lzbd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_out_byte  = result.data;
    assign o_out_last  = result.last;
    assign o_out_error = result.err;

endmodule

### src/lzbd_checker.sv
// port-level checks for the lz back-reference decompressor, with its bind
// depends on lz_backref_decompressor_defines.svh, lzbd_pkg and the top level ports
`include "lz_backref_decompressor_defines.svh"

module lzbd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_out_byte,
    input  logic        o_out_last,
    input  logic [1:0]  o_out_error
);
    // queues come out of reset drained and open
    `LZBD_ASSERT_RST(a_reset_clear, !i_rst_n |=> (empty && !full), "queues not clear after reset")

    // an error result carries a zero byte and a legal code
    `LZBD_ASSERT(a_err_zero, (!empty && o_out_error != lzbd_pkg::ERR_NONE) |-> (o_out_byte == 8'd0 && o_out_error <= lzbd_pkg::ERR_END), "bad error result")

    // every error result closes the results of its input byte
    `LZBD_ASSERT(a_err_last, (!empty && o_out_error != lzbd_pkg::ERR_NONE) |-> o_out_last, "error result not last")

    // a stalled result holds
    `LZBD_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_out_error)), "result changed while stalled")

endmodule

bind lz_backref_decompressor lzbd_checker u_lzbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_out_byte  (o_out_byte),
    .o_out_last  (o_out_last),
    .o_out_error (o_out_error)
);

### test/lz_backref_decompressor_tb.sv
// self-checking testbench of the lz back-reference decompressor
// depends on lzbd_pkg and lz_backref_decompressor; a directed table then random
// token streams, each result checked against a behavioral decoder or its table row
module lz_backref_decompressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH   = lzbd_pkg::HISTORY_DEPTH_DEF;
    localparam int RAND_ITEMS   = 75;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 16;
    localparam int NUM_DIRECTED = 25;

    // where the decoder stands inside a token
    typedef enum logic [1:0] {
        ST_CTRL,
        ST_LITERAL,
        ST_DIST_HI,
        ST_DIST_LO
    } t_parse_st;

    // one directed transaction; typed rows carry the single result they must give
    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
        logic       typed;
        logic [7:0] want_data;
        logic [1:0] want_err;
    } t_dir_row;

    t_dir_row dir_tab [NUM_DIRECTED] = '{
        // stream with literals, short and long copies, overlap and a far distance
        '{8'h01, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // literal run of two
        '{8'h00, 1'b0, 1'b1, 8'h00, lzbd_pkg::ERR_NONE},   // lowest byte passes through
        '{8'hff, 1'b0, 1'b1, 8'hff, lzbd_pkg::ERR_NONE},   // highest byte passes through
        '{8'hc0, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // copy of one, one distance byte
        '{8'h00, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // distance one
        '{8'hff, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // copy of 64, one distance byte
        '{8'h02, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // distance three, source overlaps
        '{8'h80, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // copy of one, two distance bytes
        '{8'hff, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // high distance byte
        '{8'hff, 1'b0, 1'b1, 8'h00, lzbd_pkg::ERR_DIST},   // distance 65536, too far back
        '{8'hbf, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // copy of 64, two distance bytes
        '{8'h00, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},   // distance one, 64 repeats
        '{8'h7f, 1'b1, 1'b1, 8'h00, lzbd_pkg::ERR_END},    // longest literal run, stream cut
        // distance check on an empty stream
        '{8'hc0, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b1, 8'h00, lzbd_pkg::ERR_DIST},
        // literal byte followed by the end-of-stream error
        '{8'h01, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'h5a, 1'b1, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        // stream ends while the high distance byte is awaited
        '{8'h80, 1'b1, 1'b1, 8'h00, lzbd_pkg::ERR_END},
        // copy that closes a stream cleanly
        '{8'h00, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'h33, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'hc1, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        // stream ends while the low distance byte is awaited
        '{8'h81, 1'b0, 1'b0, 8'h00, lzbd_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1'b1, 8'h00, lzbd_pkg::ERR_END}
    };

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic [1:0] o_out_error;

    // decoder state, mirrors the block
    t_parse_st   pst;
    int unsigned lit_left;
    int unsigned copy_len;
    int unsigned dist_hi;
    int unsigned produced;
    int unsigned wr_ptr;
    logic [7:0]  hist_mem [HIST_DEPTH];

    lzbd_pkg::t_result step_out [$];       // results of the byte just decoded
    lzbd_pkg::t_result owed_results [$];   // results still to be delivered, oldest first

    int  n_fail     = 0;
    int  n_checked  = 0;
    int  n_sent     = 0;
    int  n_streams  = 0;
    int  n_copies   = 0;
    int  cycles     = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;

    lz_backref_decompressor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    always #4 i_clk = ~i_clk;

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[lz_backref_decompressor] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_fail++;
    endtask

    // idle length: mostly none or short, now and then long, none in steady stretches
    function automatic int pick_gap(input logic steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void clear_stream();
        pst      = ST_CTRL;
        lit_left = 0;
        copy_len = 0;
        dist_hi  = 0;
        produced = 0;
        wr_ptr   = 0;
    endfunction

    function automatic void emit(input logic [7:0] data, input logic [1:0] err);
        lzbd_pkg::t_result r;
        r.data = data;
        r.last = 1'b0;
        r.err  = err;
        step_out.insert(step_out.size(), r);
    endfunction

    // append one output byte to the history window
    function automatic void keep(input logic [7:0] data);
        hist_mem[wr_ptr] = data;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (produced < HIST_DEPTH)
            produced++;
    endfunction

    // decode one compressed byte into step_out
    function automatic void decode_step(input logic [7:0] code, input logic is_last);
        int unsigned       distance;
        logic [7:0]        v;
        lzbd_pkg::t_result r;
        step_out.delete();
        case (pst)
            ST_CTRL: begin
                if (!code[7]) begin
                    lit_left = code + 1;
                    pst = ST_LITERAL;
                end else begin
                    copy_len = (code & lzbd_pkg::LEN_MASK) + 1;
                    dist_hi = 0;
                    pst = code[6] ? ST_DIST_LO : ST_DIST_HI;
                end
            end
            ST_LITERAL: begin
                emit(code, lzbd_pkg::ERR_NONE);
                keep(code);
                lit_left--;
                if (lit_left == 0)
                    pst = ST_CTRL;
            end
            ST_DIST_HI: begin
                dist_hi = code;
                pst = ST_DIST_LO;
            end
            default: begin
                distance = (dist_hi << 8) + code + 1;
                pst = ST_CTRL;
                dist_hi = 0;
                if (distance > produced) begin
                    emit(8'h00, lzbd_pkg::ERR_DIST);
                end else begin
                    // byte by byte so an overlapping source sees fresh output
                    for (int i = 0; i < copy_len; i++) begin
                        v = hist_mem[(wr_ptr + HIST_DEPTH - distance) % HIST_DEPTH];
                        emit(v, lzbd_pkg::ERR_NONE);
                        keep(v);
                    end
                end
                copy_len = 0;
            end
        endcase
        if (is_last) begin
            if (pst != ST_CTRL)
                emit(8'h00, lzbd_pkg::ERR_END);
            clear_stream();
        end
        if (step_out.size() > 0) begin
            r = step_out[step_out.size() - 1];
            r.last = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
    endfunction

    // one input transaction: hold push until taken, then decode and maybe idle
    task automatic send_byte(input logic [7:0] code, input logic is_last,
                             input logic typed, input lzbd_pkg::t_result typed_res);
        int g;
        push      <= 1'b1;
        i_in_byte <= code;
        i_in_last <= is_last;
        do @(posedge i_clk); while (full);
        decode_step(code, is_last);
        if (typed)
            owed_results.insert(owed_results.size(), typed_res);
        else
            owed_results = {owed_results, step_out};
        n_sent++;
        if ($urandom_range(0, 29) == 0)
            tx_steady = !tx_steady;
        g = pick_gap(tx_steady);
        if (g > 0) begin
            // garbage on the data lines while push is low
            push      <= 1'b0;
            i_in_byte <= 8'($urandom_range(0, 255));
            i_in_last <= 1'($urandom_range(0, 1));
            repeat (g) @(posedge i_clk);
        end
    endtask

    // result side: random pop with short and long stalls
    initial begin
        int hold;
        int g;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            pop <= 1'b1;
            hold = $urandom_range(1, 24);
            repeat (hold) @(posedge i_clk);
            if ($urandom_range(0, 15) == 0)
                rx_steady = !rx_steady;
            g = pick_gap(rx_steady);
            if (g > 0) begin
                pop <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // compare every popped result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        lzbd_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result data %02h last %0b err %0d",
                                          o_out_byte, o_out_last, o_out_error));
            end else begin
                want = owed_results.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("result %0d data %02h, want %02h",
                                              n_checked, o_out_byte, want.data));
                if (o_out_last !== want.last)
                    report_mismatch($sformatf("result %0d last %0b, want %0b",
                                              n_checked, o_out_last, want.last));
                if (o_out_error !== want.err)
                    report_mismatch($sformatf("result %0d err %0d, want %0d",
                                              n_checked, o_out_error, want.err));
                n_checked++;
            end
        end
    end

    // stimulus
    initial begin
        int                r;
        int                clen;
        int                llen;
        int                d;
        int                dcode;
        int                keep_n;
        int                rand_base;
        logic              end_it;
        logic              paused;
        lzbd_pkg::t_result tr;
        t_dir_row          row;
        logic [7:0]        tok [$];

        clear_stream();
        paused = 1'b0;
        tr = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed rows are checked against their written result
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            row = dir_tab[k];
            tr.data = row.want_data;
            tr.last = 1'b1;
            tr.err  = row.want_err;
            send_byte(row.code, row.is_last, row.typed, tr);
            if (row.is_last)
                n_streams++;
        end
        tr = '0;

        // random token streams: mostly well-formed, some noise and cut streams
        rand_base = n_sent;
        while (n_sent - rand_base < RAND_ITEMS) begin
            // sender holds off once until the block has drained completely
            if (!paused && n_sent - rand_base >= RAND_ITEMS / 2) begin
                paused = 1'b1;
                push <= 1'b0;
                do @(posedge i_clk); while (owed_results.size() != 0);
            end
            tok.delete();
            r = $urandom_range(0, 99);
            if (r < 40 || (produced == 0 && r < 75)) begin
                // literal run, now and then a long one
                llen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 5);
                tok.insert(tok.size(), llen[7:0]);
                repeat (llen + 1) tok.insert(tok.size(), 8'($urandom_range(0, 255)));
            end else if (r < 85) begin
                // copy: in reach of the history, or past the start of the stream
                clen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 7);
                if (r < 75) begin
                    d = ($urandom_range(0, 1) == 0) ?
                        $urandom_range(1, (produced < 16) ? produced : 16) :
                        $urandom_range(1, produced);
                end else begin
                    d = produced + $urandom_range(1, 400);
                    if (d > HIST_DEPTH)
                        d = HIST_DEPTH;
                end
                dcode = d - 1;
                n_copies++;
                if (d <= 256 && $urandom_range(0, 1) == 1) begin
                    tok.insert(tok.size(), 8'hc0 | clen[7:0]);
                    tok.insert(tok.size(), dcode[7:0]);
                end else begin
                    tok.insert(tok.size(), 8'h80 | clen[7:0]);
                    tok.insert(tok.size(), dcode[15:8]);
                    tok.insert(tok.size(), dcode[7:0]);
                end
            end else begin
                // stray byte, may knock the parser out of step
                tok.insert(tok.size(), 8'($urandom_range(0, 255)));
            end
            end_it = ($urandom_range(0, 99) < 10);
            if (tok.size() > 1 && $urandom_range(0, 99) < 8) begin
                // cut the token short and end the stream there
                keep_n = $urandom_range(1, tok.size() - 1);
                while (tok.size() > keep_n)
                    void'(tok.pop_back());
                end_it = 1'b1;
            end
            // keep the byte count within the budget
            while (n_sent - rand_base + tok.size() > RAND_ITEMS)
                void'(tok.pop_back());
            foreach (tok[k])
                send_byte(tok[k], end_it && (k == tok.size() - 1), 1'b0, tr);
            if (end_it)
                n_streams++;
        end

        // drain, then leave room for stray results
        push <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d compressed bytes in %0d closed streams, %0d random copy tokens",
                 n_sent, n_streams, n_copies);
        $display("checked %0d decompressed results, %0d mismatches", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("[lz_backref_decompressor] OK");
        end else begin
            $display("[lz_backref_decompressor] ERROR");
        end
        $finish;
    end

endmodule

### lz_backref_decompressor.f
+incdir+src
src/lzbd_pkg.sv
src/lzbd_fifo.sv
src/lzbd_front.sv
src/lzbd_back.sv
src/lz_backref_decompressor.sv
src/lzbd_checker.sv
test/lz_backref_decompressor_tb.sv
